FILE: rtl/core/ofr_pkg.sv
// Shared types, codes and the CRC-8 step for the object frame receiver.
// No dependencies; used by every module of the receiver.
package ofr_pkg;

   localparam int unsigned MaxFrameLenDefault = 265;
   localparam logic [7:0]  SyncByte           = 8'h3c;
   localparam int unsigned HeaderLen          = 10;
   localparam logic [7:0]  CrcPoly            = 8'h07;

   typedef enum logic [3:0] {
      PH_HUNT = 4'd0,
      PH_TYPE = 4'd1,
      PH_LEN0 = 4'd2,
      PH_LEN1 = 4'd3,
      PH_OID0 = 4'd4,
      PH_OID1 = 4'd5,
      PH_OID2 = 4'd6,
      PH_OID3 = 4'd7,
      PH_IID0 = 4'd8,
      PH_IID1 = 4'd9,
      PH_DATA = 4'd10,
      PH_CRC  = 4'd11
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_CRC_GOOD = 2'd1,
      KIND_CRC_BAD  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      logic [7:0]  payload_index;
      logic [7:0]  message_type;
      logic [15:0] instance_id;
      logic [7:0]  payload_length;
   } rsp_type;

   // One byte through the MSB-first CRC-8, no reflection, no final xor.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/core/ofr_parser.sv
// Frame parser: phase register, running CRC and header fields, one byte per step.
// Depends on ofr_pkg.
module ofr_parser #(
   parameter int unsigned MaxFrameLen = ofr_pkg::MaxFrameLenDefault
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      rx_byte,
   input  logic [31:0]     expected_id,
   output logic            emit_valid,
   output ofr_pkg::rsp_type emit
);

   localparam logic [15:0] MaxLen = 16'(MaxFrameLen);
   localparam logic [15:0] MinLen = 16'(ofr_pkg::HeaderLen);
   localparam logic [8:0]  HdrLen9 = 9'(ofr_pkg::HeaderLen);

   ofr_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  crc_ff, crc_in;
   logic [8:0]  length_ff, length_in;
   logic [8:0]  position_ff, position_in;
   logic [31:0] object_id_ff, object_id_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] instance_ff, instance_in;

   logic [7:0]  crc_next;
   logic [15:0] total_len;
   logic [31:0] full_id;
   logic [8:0]  position_inc;
   logic [9:0]  position_end;
   logic [8:0]  length_less_hdr;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ofr_pkg::PH_HUNT;
         crc_ff       <= '0;
         length_ff    <= '0;
         position_ff  <= '0;
         object_id_ff <= '0;
         type_ff      <= '0;
         instance_ff  <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         crc_ff       <= crc_in;
         length_ff    <= length_in;
         position_ff  <= position_in;
         object_id_ff <= object_id_in;
         type_ff      <= type_in;
         instance_ff  <= instance_in;
      end
   end

   always_comb begin
      crc_next        = ofr_pkg::crc8_update(crc_ff, rx_byte);
      total_len       = {rx_byte, length_ff[7:0]};
      full_id         = {rx_byte, object_id_ff[23:0]};
      position_inc    = position_ff + 9'd1;
      position_end    = {1'b0, position_inc} + {1'b0, HdrLen9};
      length_less_hdr = length_ff - HdrLen9;

      phase_in     = phase_ff;
      crc_in       = crc_next;
      length_in    = length_ff;
      position_in  = position_ff;
      object_id_in = object_id_ff;
      type_in      = type_ff;
      instance_in  = instance_ff;
      emit_valid   = 1'b0;

      emit.kind           = ofr_pkg::KIND_PAYLOAD;
      emit.payload_byte   = '0;
      emit.payload_index  = '0;
      emit.message_type   = type_ff;
      emit.instance_id    = instance_ff;
      emit.payload_length = length_less_hdr[7:0];

      unique case (phase_ff)
         ofr_pkg::PH_HUNT: begin
            // The CRC restarts from zero on the sync byte.
            crc_in = ofr_pkg::crc8_update(8'h00, rx_byte);
            if (rx_byte == ofr_pkg::SyncByte) begin
               phase_in = ofr_pkg::PH_TYPE;
            end else begin
               crc_in = crc_ff;
            end
         end
         ofr_pkg::PH_TYPE: begin
            type_in  = rx_byte;
            phase_in = ofr_pkg::PH_LEN0;
         end
         ofr_pkg::PH_LEN0: begin
            length_in = {1'b0, rx_byte};
            phase_in  = ofr_pkg::PH_LEN1;
         end
         ofr_pkg::PH_LEN1: begin
            if (total_len < MinLen || total_len > MaxLen) begin
               phase_in = ofr_pkg::PH_HUNT;
            end else begin
               length_in = total_len[8:0];
               phase_in  = ofr_pkg::PH_OID0;
            end
         end
         ofr_pkg::PH_OID0: begin
            object_id_in = {24'h0, rx_byte};
            phase_in     = ofr_pkg::PH_OID1;
         end
         ofr_pkg::PH_OID1: begin
            object_id_in[15:8] = rx_byte;
            phase_in           = ofr_pkg::PH_OID2;
         end
         ofr_pkg::PH_OID2: begin
            object_id_in[23:16] = rx_byte;
            phase_in            = ofr_pkg::PH_OID3;
         end
         ofr_pkg::PH_OID3: begin
            object_id_in = full_id;
            phase_in     = (full_id == expected_id) ? ofr_pkg::PH_IID0 : ofr_pkg::PH_HUNT;
         end
         ofr_pkg::PH_IID0: begin
            instance_in = {8'h00, rx_byte};
            phase_in    = ofr_pkg::PH_IID1;
         end
         ofr_pkg::PH_IID1: begin
            instance_in[15:8] = rx_byte;
            position_in       = '0;
            phase_in          = (length_ff > HdrLen9) ? ofr_pkg::PH_DATA : ofr_pkg::PH_CRC;
         end
         ofr_pkg::PH_DATA: begin
            emit_valid         = 1'b1;
            emit.payload_byte  = rx_byte;
            emit.payload_index = position_ff[7:0];
            position_in        = position_inc;
            if (position_end >= {1'b0, length_ff}) begin
               phase_in = ofr_pkg::PH_CRC;
            end
         end
         ofr_pkg::PH_CRC: begin
            emit_valid = 1'b1;
            emit.kind  = (rx_byte == crc_ff) ? ofr_pkg::KIND_CRC_GOOD
                                             : ofr_pkg::KIND_CRC_BAD;
            crc_in     = crc_ff;
            phase_in   = ofr_pkg::PH_HUNT;
         end
         default: begin
            crc_in   = crc_ff;
            phase_in = ofr_pkg::PH_HUNT;
         end
      endcase
   end

endmodule

FILE: rtl/core/ofr_rsp_stage.sv
// Result register: holds one parsed word until the consumer takes it.
// Depends on ofr_pkg.
module ofr_rsp_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  ofr_pkg::rsp_type load_data,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output ofr_pkg::rsp_type rsp_data
);

   logic             valid_ff, valid_in;
   ofr_pkg::rsp_type data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: rtl/core/object_frame_receiver.sv
// Object frame receiver: byte-serial frame parser with CRC-8 check.
// A held word is parsed and its result loaded once the result slot is free or draining.
// Throughput: one word per cycle; a result the consumer holds stalls input after one word.
// Reset (synchronous, active high) returns to sync hunting and clears the object id.
// Depends on ofr_pkg, ofr_parser and ofr_rsp_stage.
module object_frame_receiver #(
   parameter int unsigned MaxFrameLen = ofr_pkg::MaxFrameLenDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_payload_index,
   output logic [7:0]  rsp_message_type,
   output logic [15:0] rsp_instance_id,
   output logic [7:0]  rsp_payload_length
);

   logic [31:0]      expected_id_ff;
   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff, in_byte_in;
   logic             advance;
   logic             emit_valid;
   ofr_pkg::rsp_type emit;
   ofr_pkg::rsp_type rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff <= '0;
      end else if (csr_wr_en) begin
         expected_id_ff <= csr_wr_data;
      end
   end

   // The held word moves into the parser only when the result slot is free or draining.
   assign advance   = in_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   ofr_parser #(
      .MaxFrameLen(MaxFrameLen)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .rx_byte    (in_byte_ff),
      .expected_id(expected_id_ff),
      .emit_valid (emit_valid),
      .emit       (emit)
   );

   ofr_rsp_stage u_rsp_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && emit_valid),
      .load_data(emit),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   assign rsp_kind           = rsp_data.kind;
   assign rsp_payload_byte   = rsp_data.payload_byte;
   assign rsp_payload_index  = rsp_data.payload_index;
   assign rsp_message_type   = rsp_data.message_type;
   assign rsp_instance_id    = rsp_data.instance_id;
   assign rsp_payload_length = rsp_data.payload_length;

endmodule

FILE: dv/tb_top.sv
// Self-checking bench for object_frame_receiver: directed frames, then random frames under
// several object id settings, each result checked against an in-bench frame parser or a table's expected word.
// Depends on ofr_pkg and the receiver RTL.
`timescale 1ns / 100ps

module tb_top;

   localparam int unsigned CycleLimit   = 600000;
   localparam int unsigned ItemsPerStep = 180;

   typedef enum logic [1:0] {
      FILL_AS_IS    = 2'd0,
      FILL_GOOD_CRC = 2'd1,
      FILL_BAD_CRC  = 2'd2
   } fill_type;

   typedef struct packed {
      logic [7:0]       rx;
      fill_type         fill;
      logic             typed;
      ofr_pkg::rsp_type want;
   } stim_row_type;

   localparam ofr_pkg::rsp_type NoWord = '0;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_payload_byte;
   logic [7:0]  rsp_payload_index;
   logic [7:0]  rsp_message_type;
   logic [15:0] rsp_instance_id;
   logic [7:0]  rsp_payload_length;

   // Parser copy that tracks the receiver one accepted word at a time.
   ofr_pkg::phase_type prs_phase;
   logic [7:0]  prs_crc;
   logic [8:0]  prs_len;
   logic [8:0]  prs_pos;
   logic [31:0] prs_oid;
   logic [7:0]  prs_type;
   logic [15:0] prs_iid;
   logic [31:0] cfg_oid;

   ofr_pkg::rsp_type owed_words [$];
   int unsigned words_taken;
   int unsigned fail_count;
   int unsigned cycle_count;
   int unsigned out_stall;
   logic        calm_in;
   logic        calm_out;

   stim_row_type stim_rows [0:23] = '{
      '{8'h5a, FILL_AS_IS, 1'b0, NoWord},
      '{8'h3c, FILL_AS_IS, 1'b0, NoWord},
      '{8'hff, FILL_AS_IS, 1'b0, NoWord},
      '{8'h0a, FILL_AS_IS, 1'b0, NoWord},
      '{8'h00, FILL_AS_IS, 1'b0, NoWord},
      '{8'h00, FILL_AS_IS, 1'b0, NoWord},
      '{8'h00, FILL_AS_IS, 1'b0, NoWord},
      '{8'h00, FILL_AS_IS, 1'b0, NoWord},
      '{8'h00, FILL_AS_IS, 1'b0, NoWord},
      '{8'hff, FILL_AS_IS, 1'b0, NoWord},
      '{8'hff, FILL_AS_IS, 1'b0, NoWord},
      '{8'h00, FILL_GOOD_CRC, 1'b1,
        '{ofr_pkg::KIND_CRC_GOOD, 8'h00, 8'h00, 8'hff, 16'hffff, 8'h00}},
      '{8'h3c, FILL_AS_IS, 1'b0, NoWord},
      '{8'h00, FILL_AS_IS, 1'b0, NoWord},
      '{8'h0a, FILL_AS_IS, 1'b0, NoWord},
      '{8'h01, FILL_AS_IS, 1'b0, NoWord},
      '{8'h3c, FILL_AS_IS, 1'b0, NoWord},
      '{8'h00, FILL_AS_IS, 1'b0, NoWord},
      '{8'h0a, FILL_AS_IS, 1'b0, NoWord},
      '{8'h00, FILL_AS_IS, 1'b0, NoWord},
      '{8'h00, FILL_AS_IS, 1'b0, NoWord},
      '{8'h00, FILL_AS_IS, 1'b0, NoWord},
      '{8'h00, FILL_AS_IS, 1'b0, NoWord},
      '{8'h80, FILL_AS_IS, 1'b0, NoWord}
   };

   object_frame_receiver dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_index  (rsp_payload_index),
      .rsp_message_type   (rsp_message_type),
      .rsp_instance_id    (rsp_instance_id),
      .rsp_payload_length (rsp_payload_length)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Bitwise form of the CRC-8 step: feedback is the top CRC bit xor the next data bit.
   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[7] ^ b[i];
         c  = {c[6:0], 1'b0};
         if (fb) begin
            c = c ^ ofr_pkg::CrcPoly;
         end
      end
      return c;
   endfunction

   function automatic int unsigned gap_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 20);
   endfunction

   task automatic report_fail(input string msg);
      $display("%0t ERROR: %s", $time, msg);
      fail_count++;
   endtask

   task automatic frame_parse_step(input logic [7:0] b, output logic produced,
                                   output ofr_pkg::rsp_type word);
      logic [15:0] total;
      logic [8:0]  pay_len;
      produced = 1'b0;
      word     = NoWord;
      case (prs_phase)
         ofr_pkg::PH_HUNT: begin
            if (b == ofr_pkg::SyncByte) begin
               prs_crc   = crc8_next(8'h00, b);
               prs_phase = ofr_pkg::PH_TYPE;
            end
         end
         ofr_pkg::PH_TYPE: begin
            prs_type  = b;
            prs_crc   = crc8_next(prs_crc, b);
            prs_phase = ofr_pkg::PH_LEN0;
         end
         ofr_pkg::PH_LEN0: begin
            prs_len   = {1'b0, b};
            prs_crc   = crc8_next(prs_crc, b);
            prs_phase = ofr_pkg::PH_LEN1;
         end
         ofr_pkg::PH_LEN1: begin
            total   = {b, prs_len[7:0]};
            prs_crc = crc8_next(prs_crc, b);
            if (total < ofr_pkg::HeaderLen || total > ofr_pkg::MaxFrameLenDefault) begin
               prs_phase = ofr_pkg::PH_HUNT;
            end else begin
               prs_len   = total[8:0];
               prs_phase = ofr_pkg::PH_OID0;
            end
         end
         ofr_pkg::PH_OID0, ofr_pkg::PH_OID1, ofr_pkg::PH_OID2: begin
            prs_oid   = {b, prs_oid[31:8]};
            prs_crc   = crc8_next(prs_crc, b);
            prs_phase = ofr_pkg::phase_type'(prs_phase + 4'd1);
         end
         ofr_pkg::PH_OID3: begin
            prs_oid   = {b, prs_oid[31:8]};
            prs_crc   = crc8_next(prs_crc, b);
            prs_phase = (prs_oid == cfg_oid) ? ofr_pkg::PH_IID0 : ofr_pkg::PH_HUNT;
         end
         ofr_pkg::PH_IID0: begin
            prs_iid   = {8'h00, b};
            prs_crc   = crc8_next(prs_crc, b);
            prs_phase = ofr_pkg::PH_IID1;
         end
         ofr_pkg::PH_IID1: begin
            prs_iid   = {b, prs_iid[7:0]};
            prs_crc   = crc8_next(prs_crc, b);
            prs_pos   = '0;
            prs_phase = (prs_len > ofr_pkg::HeaderLen) ? ofr_pkg::PH_DATA : ofr_pkg::PH_CRC;
         end
         ofr_pkg::PH_DATA, ofr_pkg::PH_CRC: begin
            pay_len             = prs_len - 9'(ofr_pkg::HeaderLen);
            produced            = 1'b1;
            word.message_type   = prs_type;
            word.instance_id    = prs_iid;
            word.payload_length = pay_len[7:0];
            if (prs_phase == ofr_pkg::PH_DATA) begin
               prs_crc            = crc8_next(prs_crc, b);
               word.kind          = ofr_pkg::KIND_PAYLOAD;
               word.payload_byte  = b;
               word.payload_index = prs_pos[7:0];
               prs_pos            = prs_pos + 9'd1;
               if (prs_pos + ofr_pkg::HeaderLen >= prs_len) begin
                  prs_phase = ofr_pkg::PH_CRC;
               end
            end else begin
               word.kind = (b == prs_crc) ? ofr_pkg::KIND_CRC_GOOD : ofr_pkg::KIND_CRC_BAD;
               prs_phase = ofr_pkg::PH_HUNT;
            end
         end
         default: begin
            prs_phase = ofr_pkg::PH_HUNT;
         end
      endcase
   endtask

   // Called at a rising edge; returns at the edge where the word is accepted.
   task automatic push_byte(input logic [7:0] b, input logic typed,
                            input ofr_pkg::rsp_type want);
      int unsigned      gap;
      logic             produced;
      ofr_pkg::rsp_type word;
      gap = calm_in ? 0 : gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do begin
         @(posedge clock);
      end while (!req_ready);
      words_taken++;
      frame_parse_step(b, produced, word);
      if (produced) begin
         owed_words.push_back(typed ? want : word);
      end
   endtask

   task automatic write_object_id(input logic [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_oid = value;
   endtask

   // Feed zeros until the parser is back to hunting, then drain the results.
   task automatic settle();
      while (prs_phase != ofr_pkg::PH_HUNT) begin
         push_byte(8'h00, 1'b0, NoWord);
      end
      req_valid <= 1'b0;
      while (owed_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic send_frame();
      logic [7:0]  bytes [$];
      logic [7:0]  crc;
      logic [15:0] total;
      logic [15:0] iid;
      logic [31:0] oid;
      int unsigned pay;
      int unsigned r;
      int unsigned cut;
      r = $urandom_range(0, 99);
      if (r < 6) begin
         case ($urandom_range(0, 3))
            0: total = 16'd0;
            1: total = 16'd9;
            2: total = 16'd266;
            default: total = 16'($urandom_range(266, 65535));
         endcase
         pay = 0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 3) begin
            pay = 255;
         end else if (r < 10) begin
            pay = $urandom_range(200, 254);
         end else begin
            pay = $urandom_range(0, 12);
         end
         total = 16'(pay + ofr_pkg::HeaderLen);
      end
      r = $urandom_range(0, 99);
      if (r < 80) begin
         oid = cfg_oid;
      end else if (r < 90) begin
         oid = cfg_oid ^ (32'h1 << $urandom_range(0, 31));
      end else begin
         oid = $urandom;
      end
      iid = 16'($urandom);
      bytes.push_back(ofr_pkg::SyncByte);
      bytes.push_back(8'($urandom));
      bytes.push_back(total[7:0]);
      bytes.push_back(total[15:8]);
      for (int i = 0; i < 4; i++) begin
         bytes.push_back(oid[8*i +: 8]);
      end
      bytes.push_back(iid[7:0]);
      bytes.push_back(iid[15:8]);
      for (int i = 0; i < pay; i++) begin
         bytes.push_back(8'($urandom));
      end
      crc = 8'h00;
      foreach (bytes[i]) begin
         crc = crc8_next(crc, bytes[i]);
      end
      bytes.push_back(($urandom_range(0, 99) < 85) ? crc : crc ^ 8'($urandom_range(1, 255)));
      // A broken frame stops early; the next frame's bytes land in its remaining fields.
      if ($urandom_range(0, 99) < 8) begin
         cut = $urandom_range(1, bytes.size() - 1);
         while (bytes.size() > cut) begin
            void'(bytes.pop_back());
         end
      end
      if ($urandom_range(0, 99) < 30) begin
         repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0, NoWord);
      end
      foreach (bytes[i]) begin
         push_byte(bytes[i], 1'b0, NoWord);
      end
   endtask

   // Stretches with no idling come and go on each side.
   always @(posedge clock) begin
      if (cycle_count % 256 == 0) begin
         calm_in  <= ($urandom_range(0, 3) == 0);
         calm_out <= ($urandom_range(0, 3) == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      ofr_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_words.size() == 0) begin
            report_fail($sformatf("unexpected word, kind %0d", rsp_kind));
         end else begin
            want = owed_words.pop_front();
            if (rsp_kind !== want.kind)
               report_fail($sformatf("kind %0d, want %0d", rsp_kind, want.kind));
            if (rsp_payload_byte !== want.payload_byte)
               report_fail($sformatf("payload_byte %0h, want %0h",
                                     rsp_payload_byte, want.payload_byte));
            if (rsp_payload_index !== want.payload_index)
               report_fail($sformatf("payload_index %0d, want %0d",
                                     rsp_payload_index, want.payload_index));
            if (rsp_message_type !== want.message_type)
               report_fail($sformatf("message_type %0h, want %0h",
                                     rsp_message_type, want.message_type));
            if (rsp_instance_id !== want.instance_id)
               report_fail($sformatf("instance_id %0h, want %0h",
                                     rsp_instance_id, want.instance_id));
            if (rsp_payload_length !== want.payload_length)
               report_fail($sformatf("payload_length %0d, want %0d",
                                     rsp_payload_length, want.payload_length));
         end
      end
      if (out_stall > 0) begin
         out_stall = out_stall - 1;
         rsp_ready <= 1'b0;
      end else if (!calm_out && $urandom_range(0, 99) < 15) begin
         out_stall = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 25) : $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      logic [31:0]  settings [5];
      int unsigned  goal;
      int unsigned  waited;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      rsp_ready   = 1'b0;
      out_stall   = 0;
      calm_in     = 1'b0;
      calm_out    = 1'b0;
      cycle_count = 0;
      fail_count  = 0;
      words_taken = 0;
      prs_phase   = ofr_pkg::PH_HUNT;
      prs_crc     = '0;
      prs_len     = '0;
      prs_pos     = '0;
      prs_oid     = '0;
      prs_type    = '0;
      prs_iid     = '0;
      cfg_oid     = '0;
      settings    = '{32'h0000_0000, 32'hffff_ffff, $urandom, 32'h3c3c_3c3c, $urandom};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_object_id(settings[0]);
      foreach (stim_rows[i]) begin
         case (stim_rows[i].fill)
            FILL_GOOD_CRC: push_byte(prs_crc, stim_rows[i].typed, stim_rows[i].want);
            FILL_BAD_CRC:  push_byte(prs_crc ^ 8'h5a, stim_rows[i].typed, stim_rows[i].want);
            default:       push_byte(stim_rows[i].rx, stim_rows[i].typed, stim_rows[i].want);
         endcase
      end

      foreach (settings[s]) begin
         if (s != 0) begin
            settle();
            write_object_id(settings[s]);
         end
         goal = words_taken + ItemsPerStep;
         while (words_taken < goal) begin
            send_frame();
         end
      end

      req_valid <= 1'b0;
      waited = 0;
      while (owed_words.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (owed_words.size() != 0) begin
         report_fail($sformatf("%0d words never arrived", owed_words.size()));
      end
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: object_frame_receiver.f
rtl/core/ofr_pkg.sv
rtl/core/ofr_parser.sv
rtl/core/ofr_rsp_stage.sv
rtl/core/object_frame_receiver.sv
dv/tb_top.sv
